// ===== design/spectrum_peak_scale_rebin_assert.svh =====
// Assertion macros for the spectrum peak scale rebin block.
// Used by spectrum_peak_scale_rebin.sv; expects clk_i and rst_ni in scope.
`ifndef SPECTRUM_PEAK_SCALE_REBIN_ASSERT_SVH
`define SPECTRUM_PEAK_SCALE_REBIN_ASSERT_SVH

// Plain property, checked at every clock edge outside of reset.
`define SPSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: whenever ante holds, cons must hold in the same cycle.
`define SPSR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/spsr_pkg.sv =====
// Package for the spectrum peak scale rebin block: sequencer states,
// item codes and scaling constants. No dependencies.
package spsr_pkg;

  // Item kinds carried in tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Axis and scaling constants.
  localparam logic [32:0] AXIS_BASE   = 33'd500;
  localparam logic [7:0]  FULL_HEIGHT = 8'd255;
  localparam logic [8:0]  LAST_BIN    = 9'd511;

  // Scaled value saturates once (count*255 >> k) reaches 256*500.
  localparam logic [39:0] SAT_LIMIT = 40'd128000;

  // floor(y/500) for y < 128000 equals (y * RECIP_500) >> RECIP_SHIFT.
  localparam logic [17:0] RECIP_500   = 18'd134218;
  localparam int          RECIP_SHIFT = 26;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_AXIS,
    S_RD,
    S_SC,
    S_ACC,
    S_OUT
  } spsr_state_e;

endpackage

// ===== design/spectrum_peak_scale_rebin.sv =====
// Spectrum peak scale rebin: channel store, peak tracking, axis search and a shared
// scale/accumulate unit under a small sequencer; uses spsr_pkg and the assert header.
// Items are accepted only in S_IDLE; a load item is done once accepted. For a read item, S_AXIS
// doubles the axis k times (0..24), then S_RD, S_SC and S_ACC run for each of the n channels per bin
// (1..8), and S_OUT raises m_axis_tvalid and returns to S_IDLE; a held result stalls it in S_OUT.
// Reset clears the sequencer, peak and output valid and sets 512 channels; the store is kept.
`include "spectrum_peak_scale_rebin_assert.svh"

module spectrum_peak_scale_rebin
  import spsr_pkg::*;
#(
  parameter int MAX_CHANNELS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: channel_mode.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: channel_index[11:0], channel_count[43:12], bin_index[52:44], zero fill.
  input  logic [55:0] s_axis_tdata,
  // tuser: op.
  input  logic        s_axis_tuser,
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: bin_value[7:0], axis_top[40:8], zero fill.
  output logic [47:0] m_axis_tdata
);

  localparam int AW = $clog2(MAX_CHANNELS);

  // Largest channel mode whose channels fit the store.
  function automatic int max_mode_f(int maxch);
    int m;
    m = 4;
    while (m > 0 && (256 << m) > maxch) m--;
    return m;
  endfunction

  localparam int MaxMode = max_mode_f(MAX_CHANNELS);

  // Input field extraction.
  logic [11:0] in_ch;
  logic [31:0] in_cnt;
  logic [8:0]  in_bin;
  assign in_ch  = s_axis_tdata[11:0];
  assign in_cnt = s_axis_tdata[43:12];
  assign in_bin = s_axis_tdata[52:44];

  spsr_state_e state_q, state_d;

  logic [2:0]  channel_mode_q;
  logic [31:0] peak_q;
  logic [32:0] top_q;
  logic [4:0]  sh_q;
  logic [11:0] base_q;
  logic [1:0]  nlog_q;
  logic [2:0]  k_q;
  logic [31:0] rd_data_q;
  logic [16:0] y_q;
  logic        sat_q;
  logic [10:0] sum_q;
  logic        out_valid_q;
  logic [7:0]  out_bin_q;
  logic [32:0] out_top_q;

  logic [31:0] mem [MAX_CHANNELS];

  // Effective mode, limited to 4 and to what the store holds.
  logic [2:0] mode_eff;
  always_comb begin
    mode_eff = (channel_mode_q > 3'd4) ? 3'd4 : channel_mode_q;
    if (mode_eff > 3'(MaxMode)) mode_eff = 3'(MaxMode);
  end

  // Handshake and status decode.
  logic accept, is_load, is_read, axis_more, last_ch, out_free;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_load   = accept && (s_axis_tuser == OP_LOAD);
  assign is_read   = accept && (s_axis_tuser == OP_READ);
  assign axis_more = {1'b0, peak_q} > top_q;
  assign last_ch   = {1'b0, k_q} == ((4'd1 << nlog_q) - 4'd1);
  assign out_free  = !out_valid_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (is_read) state_d = S_AXIS;
      S_AXIS:  if (!axis_more) state_d = S_RD;
      S_RD:    state_d = S_SC;
      S_SC:    state_d = S_ACC;
      S_ACC:   state_d = last_ch ? S_OUT : S_RD;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  logic mem_re, out_load;
  always_comb begin
    s_axis_tready = 1'b0;
    mem_re        = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_RD:    mem_re = 1'b1;
      S_OUT:   out_load = out_free;
      default: ;
    endcase
  end

  // Load path: store write and peak update.
  logic        ld_store, ld_in_use;
  logic [12:0] used_ch;
  logic [11:0] rd_addr;
  assign used_ch   = 13'd256 << mode_eff;
  assign ld_store  = is_load && (32'(in_ch) < MAX_CHANNELS);
  assign ld_in_use = {1'b0, in_ch} < used_ch;
  assign rd_addr   = base_q + {9'd0, k_q};

  always_ff @(posedge clk_i) begin
    if (ld_store) mem[in_ch[AW-1:0]] <= in_cnt;
    if (mem_re)   rd_data_q <= mem[rd_addr[AW-1:0]];
  end

  // Bin setup at read acceptance: first channel and channel count.
  logic [8:0]  bin_adj;
  logic [11:0] base_d;
  logic [1:0]  nlog_d;
  always_comb begin
    bin_adj = (in_bin == LAST_BIN) ? (LAST_BIN - 9'd1) : in_bin;
    if (mode_eff == 3'd0) begin
      base_d = {4'd0, bin_adj[8:1]};
      nlog_d = {1'b0, bin_adj[0]};
    end else begin
      base_d = {3'd0, in_bin} << (mode_eff - 3'd1);
      nlog_d = 2'(mode_eff - 3'd1);
    end
  end

  // Shared scale unit: count*255 shifted by the axis exponent, then / 500.
  logic [39:0] x_scaled, y_full;
  logic [34:0] prod;
  logic [7:0]  q_val;
  assign x_scaled = {rd_data_q, 8'd0} - {8'd0, rd_data_q};
  assign y_full   = x_scaled >> sh_q;
  assign prod     = {18'd0, y_q} * {17'd0, RECIP_500};
  assign q_val    = sat_q ? FULL_HEIGHT : prod[RECIP_SHIFT+7:RECIP_SHIFT];

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      channel_mode_q <= 3'd1;
      peak_q         <= 32'd0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) channel_mode_q <= cfg_wdata_i;
      if (ld_store) begin
        if (in_ch == 12'd0) peak_q <= in_cnt;
        else if (ld_in_use && (in_cnt > peak_q)) peak_q <= in_cnt;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (is_read) begin
      top_q  <= AXIS_BASE;
      sh_q   <= 5'd0;
      base_q <= base_d;
      nlog_q <= nlog_d;
      k_q    <= 3'd0;
      sum_q  <= 11'd0;
    end
    if (state_q == S_AXIS && axis_more) begin
      top_q <= top_q << 1;
      sh_q  <= sh_q + 5'd1;
    end
    if (state_q == S_SC) begin
      y_q   <= y_full[16:0];
      sat_q <= y_full >= SAT_LIMIT;
    end
    if (state_q == S_ACC) begin
      sum_q <= sum_q + {3'd0, q_val};
      k_q   <= k_q + 3'd1;
    end
    if (out_load) begin
      out_bin_q <= 8'(sum_q >> nlog_q);
      out_top_q <= top_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_top_q, out_bin_q};

  // Checks on the sequencer and datapath.
  `SPSR_ASSERT_IMPL(a_axis_covers_peak, state_q == S_RD, ({1'b0, peak_q} <= top_q), "axis low")
  `SPSR_ASSERT_IMPL(a_mean_fits, state_q == S_OUT, (sum_q >> nlog_q) <= 11'd255, "mean overflow")
  `SPSR_ASSERT_IMPL(a_chan_in_bin, state_q == S_ACC, ({1'b0, k_q} < (4'd1 << nlog_q)), "overrun")
  `SPSR_ASSERT(a_peak_hold_busy, (state_q == S_IDLE) || $stable(peak_q), "peak moved on read")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for spectrum_peak_scale_rebin: streams channel loads and
// bin reads, predicts each display bin in-line and compares every result item.
// Depends on spsr_pkg and the RTL of spectrum_peak_scale_rebin.
module testbench;
  import spsr_pkg::*;

  localparam int          MAX_CH         = 4096;
  localparam int unsigned DRAIN_CYCLES   = 64;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned ROUND_ITEMS    = 190;

  typedef struct packed {
    logic [7:0]  height;
    logic [32:0] top;
  } bin_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_wdata_i   = 3'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: channel_index[11:0], channel_count[43:12], bin_index[52:44], zero fill.
  logic [55:0] s_axis_tdata  = '0;
  // tuser: op.
  logic        s_axis_tuser  = OP_LOAD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: bin_value[7:0], axis_top[40:8], zero fill.
  logic [47:0] m_axis_tdata;

  // Shadow copy of the block state used for prediction.
  logic [31:0] count_mem  [MAX_CH];
  bit          loaded_mem [MAX_CH];
  logic [31:0] peak_q     = '0;
  logic [2:0]  mode_q     = 3'd1;

  bin_result_t pending_bins[$];
  int unsigned items_sent     = 0;
  int unsigned mismatches     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned hold_left      = 0;
  bit          idle_bursts_on = 1'b1;

  spectrum_peak_scale_rebin #(
    .MAX_CHANNELS(MAX_CH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Channel mode in effect: out-of-range codes act as the widest mode that fits.
  function automatic int unsigned active_mode();
    int unsigned m;
    m = (mode_q > 3'd4) ? 4 : int'(mode_q);
    while (m > 0 && (256 << m) > MAX_CH) m--;
    return m;
  endfunction

  function automatic logic [32:0] axis_for(logic [31:0] peak);
    logic [32:0] top;
    top = AXIS_BASE;
    while ({1'b0, peak} > top) top = top << 1;
    return top;
  endfunction

  // Exact floor(count * 255 / top), saturated for stale counts above the axis.
  function automatic logic [7:0] scale_channel(int unsigned ch, logic [32:0] top);
    logic [63:0] prod;
    prod = ({32'd0, count_mem[ch]} * 64'(FULL_HEIGHT)) / 64'(top);
    return (prod > 64'(FULL_HEIGHT)) ? FULL_HEIGHT : prod[7:0];
  endfunction

  function automatic logic [7:0] display_height(int unsigned bin);
    int unsigned m, n, sum, b;
    logic [32:0] top;
    m   = active_mode();
    top = axis_for(peak_q);
    sum = 0;
    if (m == 0) begin
      // 256 channels: even bins copy, odd bins average, the last bin repeats.
      b = (bin == LAST_BIN) ? bin - 1 : bin;
      if (b % 2 == 0) return scale_channel(b >> 1, top);
      sum = scale_channel((b - 1) >> 1, top) + scale_channel((b + 1) >> 1, top);
      return 8'(sum >> 1);
    end
    n = 1 << (m - 1);
    for (int unsigned k = 0; k < n; k++) sum += scale_channel(bin * n + k, top);
    return 8'(sum >> (m - 1));
  endfunction

  // True when every channel that the bin uses in the current mode holds data.
  function automatic bit bin_loaded(int unsigned bin);
    int unsigned m, n, b;
    m = active_mode();
    if (m == 0) begin
      b = (bin == LAST_BIN) ? bin - 1 : bin;
      if (b % 2 == 0) return loaded_mem[b >> 1];
      return loaded_mem[(b - 1) >> 1] && loaded_mem[(b + 1) >> 1];
    end
    n = 1 << (m - 1);
    for (int unsigned k = 0; k < n; k++) if (!loaded_mem[bin * n + k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void store_channel(logic [11:0] ch, logic [31:0] cnt);
    count_mem[ch]  = cnt;
    loaded_mem[ch] = 1'b1;
    if (ch == 0) peak_q = cnt;
    else if (ch < (256 << active_mode()) && cnt > peak_q) peak_q = cnt;
  endfunction

  // Counts biased toward zero, full scale and the edges of each axis doubling.
  function automatic logic [31:0] pick_count();
    logic [31:0] c;
    case ($urandom_range(0, 5))
      0:       c = $urandom_range(0, 600);
      1:       c = (32'd500 << $urandom_range(0, 23)) + $urandom_range(0, 2) - 1;
      2:       c = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      3:       c = $urandom >> $urandom_range(0, 31);
      default: c = $urandom;
    endcase
    return c;
  endfunction

  function automatic void note_failure(string what, logic [40:0] want, logic [40:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d: %s expected %0d got %0d", mismatches, what, want, got);
  endfunction

  // Offer one item, wait for its handshake and update the shadow state.
  task automatic send_item(input logic op, input logic [11:0] ch, input logic [31:0] cnt,
                           input logic [8:0] bin);
    bin_result_t r;
    if (idle_bursts_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, bin, cnt, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == OP_LOAD) begin
      store_channel(ch, cnt);
    end else begin
      r.height = display_height(bin);
      r.top    = axis_for(peak_q);
      pending_bins.push_back(r);
    end
    items_sent++;
  endtask

  task automatic send_load(input int unsigned ch, input logic [31:0] cnt);
    send_item(OP_LOAD, 12'(ch), cnt, 9'($urandom));
  endtask

  task automatic send_read(input int unsigned bin);
    send_item(OP_READ, 12'($urandom), 32'($urandom), 9'(bin));
  endtask

  // Load every channel that a bin uses in the current mode.
  task automatic load_bin_channels(input int unsigned bin);
    int unsigned m, n, b;
    m = active_mode();
    if (m == 0) begin
      b = (bin == LAST_BIN) ? bin - 1 : bin;
      send_load(b >> 1, pick_count());
      if (b % 2 == 1) send_load((b >> 1) + 1, pick_count());
    end else begin
      n = 1 << (m - 1);
      for (int unsigned k = 0; k < n; k++) send_load(bin * n + k, pick_count());
    end
  endtask

  // Stop offering items, collect every pending result and let the block settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [2:0] mode);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_q       = mode;
  endtask

  // Reset mode: axis boundaries, peak restart, load outside use and stale counts.
  task automatic test_peak_and_axis();
    send_load(0, 32'd0);
    send_read(0);
    send_load(511, 32'd500);
    send_read(511);
    send_load(1, 32'd501);
    send_read(1);
    send_load(4095, 32'hFFFF_FFFF);
    send_read(511);
    send_load(0, 32'd100);
    send_read(1);
  endtask

  // An out-of-range mode code acts as 4096 channels, eight per bin.
  task automatic test_mode_clamp();
    set_mode(3'd7);
    for (int unsigned ch = 4088; ch < 4095; ch++) send_load(ch, pick_count());
    send_read(511);
  endtask

  // 256 channels: the odd neighbor average and the repeated last bin.
  task automatic test_narrow_spectrum();
    set_mode(3'd0);
    send_load(254, 32'd12345);
    send_load(255, 32'd40000);
    send_load(256, 32'hFFFF_FFFF);
    send_read(511);
    send_read(509);
  endtask

  // Mostly whole bin groups followed by reads, with stray loads and restarts mixed in.
  task automatic test_random_round(input logic [2:0] mode);
    int unsigned stop_at, pick, b, tries;
    set_mode(mode);
    stop_at = items_sent + ROUND_ITEMS;
    send_load(0, pick_count());
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        load_bin_channels($urandom_range(0, 511));
      end else if (pick < 45) begin
        send_load($urandom_range(0, MAX_CH - 1), pick_count());
      end else if (pick < 48) begin
        send_load(0, pick_count());
      end else begin
        b     = $urandom_range(0, 511);
        tries = 0;
        while (!bin_loaded(b) && tries < 8) begin
          b = $urandom_range(0, 511);
          tries++;
        end
        if (!bin_loaded(b)) load_bin_channels(b);
        send_read(b);
      end
    end
  endtask

  // Result stalls come in random bursts while idling is enabled.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (idle_bursts_on && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= $urandom_range(0, 10);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest pending bin.
  always @(posedge clk_i) begin : result_check
    bin_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_bins.size() == 0) begin
        note_failure("unexpected result", 41'd0, m_axis_tdata[40:0]);
      end else begin
        want = pending_bins.pop_front();
        if (m_axis_tdata[7:0] !== want.height)
          note_failure("bin_value", 41'(want.height), 41'(m_axis_tdata[7:0]));
        if (m_axis_tdata[40:8] !== want.top)
          note_failure("axis_top", 41'(want.top), 41'(m_axis_tdata[40:8]));
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_peak_and_axis();
    test_mode_clamp();
    test_narrow_spectrum();
    test_random_round(3'd0);
    test_random_round(3'd4);
    test_random_round(3'd2);
    test_random_round(3'd5);
    test_random_round(3'd3);
    test_random_round(3'd1);
    test_random_round(3'd6);
    // The closing round runs with both sides at full rate.
    idle_bursts_on = 1'b0;
    test_random_round(3'd7);
    wait_idle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
